[hw/rtl/sacs_pkg.sv]
`default_nettype none
package sacs_pkg;
    localparam int MAX_SEQUENCES  = 256;
    localparam int BUCKET_ENTRIES = 1024;
    localparam int MAX_CODE_BYTES = 8;
    localparam int SEQ_AW = $clog2(MAX_SEQUENCES);
    localparam int BKT_AW = $clog2(BUCKET_ENTRIES);
    localparam int RANK_W = 33;
    localparam int QDEPTH = 2;

    localparam logic [1:0] CMD_LOAD_SEQ    = 2'd0;
    localparam logic [1:0] CMD_LOAD_BUCKET = 2'd1;
    localparam logic [1:0] CMD_BEGIN       = 2'd2;
    localparam logic [1:0] CMD_SUFFIX      = 2'd3;

    localparam logic [2:0] REG_CKPT  = 3'd0;
    localparam logic [2:0] REG_PBITS = 3'd1;
    localparam logic [2:0] REG_CBYTES = 3'd2;
    localparam logic [2:0] REG_SCOUNT = 3'd3;
    localparam logic [2:0] REG_STEP  = 3'd4;

    typedef struct packed {
        logic [4:0]  ckpt;
        logic [5:0]  pbits;
        logic [3:0]  cbytes;
        logic [8:0]  scount;
        logic [31:0] step;
    } cfg_t;

    // sampled suffix handed from front to back
    typedef struct packed {
        logic [31:0] pos;
    } job_t;
endpackage
`default_nettype wire

[hw/rtl/sacs_ram.sv]
`default_nettype none
module sacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/sacs_front.sv]
`default_nettype none
module sacs_front
    import sacs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        hold,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] batch_start,
    input  wire logic [31:0] suffix_pos,
    output logic             job_valid,
    output job_t             job,
    input  wire logic        job_ready
);
    logic [RANK_W-1:0] rank_reg, rank_next;
    job_t q_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0] cnt_reg;
    logic acc, sample, deq;
    logic [RANK_W-1:0] mask;

    assign full = (cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH)) || hold;
    assign acc = push && !full;
    assign mask = (RANK_W'(1) << cfg.ckpt) - RANK_W'(1);
    assign sample = acc && (command == CMD_SUFFIX) && ((rank_reg & mask) == '0);
    assign job_valid = (cnt_reg != '0);
    assign job = q_reg[rp_reg];
    assign deq = job_valid && job_ready;

    always_comb
    begin
        rank_next = rank_reg;
        if (acc && command == CMD_BEGIN)
        begin
            rank_next = RANK_W'(batch_start) + RANK_W'(cfg.scount);
        end
        else if (acc && command == CMD_SUFFIX)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
            if (sample)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (deq)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + ($clog2(QDEPTH)+1)'(sample) - ($clog2(QDEPTH)+1)'(deq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            q_reg[wp_reg].pos <= suffix_pos;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/sacs_back.sv]
`default_nettype none
module sacs_back
    import sacs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        job_valid,
    input  wire job_t        job,
    output logic             job_ready,
    output logic [BKT_AW-1:0] bkt_raddr,
    input  wire logic [7:0]  bkt_rdata,
    output logic [SEQ_AW-1:0] seq_raddr,
    input  wire logic [31:0] start_rdata,
    input  wire logic [31:0] len_rdata,
    input  wire logic [7:0]  order_rdata,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       code_byte,
    output logic             last_byte
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_BKT  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]  st_reg;
    logic [31:0] pos_reg, quo_reg, step_reg;
    logic [32:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [SEQ_AW-1:0] idx_reg, last_seq;
    logic [63:0] val_reg;
    logic [3:0]  left_reg, nbytes;
    logic [32:0] trial;
    logic [32:0] rem_sh;
    logic [63:0] sh_order;

    assign last_seq = (cfg.scount == 9'd0) ? '0 :
                      (cfg.scount > 9'(MAX_SEQUENCES)) ? SEQ_AW'(MAX_SEQUENCES-1) :
                      SEQ_AW'(cfg.scount - 9'd1);
    assign nbytes = (cfg.cbytes == 4'd0) ? 4'd1 :
                    (cfg.cbytes > 4'(MAX_CODE_BYTES)) ? 4'(MAX_CODE_BYTES) : cfg.cbytes;
    assign job_ready = (st_reg == S_IDLE);
    assign rem_sh = {rem_reg[31:0], pos_reg[bit_reg[4:0]]};
    assign trial = rem_sh - {1'b0, step_reg};
    assign bkt_raddr = (quo_reg > 32'(BUCKET_ENTRIES-1)) ? BKT_AW'(BUCKET_ENTRIES-1)
                                                        : BKT_AW'(quo_reg);
    assign seq_raddr = idx_reg;
    assign sh_order = {56'd0, order_rdata} << cfg.pbits;
    assign empty = (st_reg != S_EMIT);
    assign code_byte = val_reg[8*(left_reg-4'd1) +: 8];
    assign last_byte = (left_reg == 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            case (st_reg)
                S_IDLE: if (job_valid) st_reg <= S_DIV;
                S_DIV:  if (bit_reg == 6'd0) st_reg <= S_BKT;
                S_BKT:  st_reg <= S_RD;
                // first pass latches the bucket entry, second waits for its sequence read
                S_RD:   st_reg <= (bit_reg == 6'h3F) ? S_RD : S_CHK;
                S_CHK:
                begin
                    if (idx_reg < last_seq &&
                        {32'd0, pos_reg} > {32'd0, start_rdata} + {32'd0, len_rdata})
                    begin
                        st_reg <= S_RD;
                    end
                    else
                    begin
                        st_reg <= S_EMIT;
                    end
                end
                S_EMIT: if (pop && left_reg == 4'd1) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle, then bucket walk
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                pos_reg <= job.pos;
                step_reg <= (cfg.step == 32'd0) ? 32'd1 : cfg.step;
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 6'd31;
            end
            S_DIV:
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                bit_reg <= bit_reg - 6'd1;
            end
            S_BKT: ;
            S_RD:
            begin
                if (bit_reg == 6'h3F)
                begin
                    idx_reg <= (SEQ_AW'(bkt_rdata) > last_seq || {1'b0, bkt_rdata} > 9'(last_seq))
                               ? last_seq : SEQ_AW'(bkt_rdata);
                    bit_reg <= 6'd0;
                end
            end
            S_CHK:
            begin
                if (idx_reg < last_seq &&
                    {32'd0, pos_reg} > {32'd0, start_rdata} + {32'd0, len_rdata})
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                begin
                    val_reg <= sh_order + ({32'd0, pos_reg} - {32'd0, start_rdata});
                    left_reg <= nbytes;
                end
            end
            S_EMIT:
            begin
                if (pop)
                begin
                    left_reg <= left_reg - 4'd1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/suffix_array_checkpoint_sampler_core.sv]
// A sampled suffix is queued, divided bit-serially by the bucket step, then its
// bucket entry is read and sequences are walked before its first code byte shows.
// The back end takes the next sampled suffix only after the last code byte is popped;
// items are accepted only while the two-entry job queue has room; table loads
// wait until the job queue is empty and the back end is idle.
// Reset: asynchronous active low; registers to 5,32,5,1,1, rank to zero, tables undefined.
`default_nettype none
module suffix_array_checkpoint_sampler_core
    import sacs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [9:0]  entry_index,
    input  wire logic [31:0] seq_start,
    input  wire logic [31:0] seq_length,
    input  wire logic [7:0]  seq_order,
    input  wire logic [7:0]  bucket_seq,
    input  wire logic [31:0] batch_start,
    input  wire logic [31:0] suffix_pos,
    input  wire logic        batch_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       code_byte,
    output logic             last_byte
);
    cfg_t cfg_reg;
    logic job_valid, job_ready, acc, seq_we, bkt_we, unused_end, hold;
    job_t job;
    logic [BKT_AW-1:0] bkt_raddr;
    logic [SEQ_AW-1:0] seq_raddr;
    logic [7:0] bkt_rdata, order_rdata;
    logic [31:0] start_rdata, len_rdata;

    assign acc = push && !full;
    // hold table loads until no queued or running job can still read the tables
    assign hold = (command == CMD_LOAD_SEQ || command == CMD_LOAD_BUCKET) &&
                  (job_valid || !job_ready);
    assign seq_we = acc && command == CMD_LOAD_SEQ && {22'd0, entry_index} < 32'(MAX_SEQUENCES);
    assign bkt_we = acc && command == CMD_LOAD_BUCKET && {22'd0, entry_index} < 32'(BUCKET_ENTRIES);
    assign unused_end = batch_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ckpt: 5'd5, pbits: 6'd32, cbytes: 4'd5, scount: 9'd1, step: 32'd1};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CKPT:   cfg_reg.ckpt <= cfg_data[4:0];
                REG_PBITS:  cfg_reg.pbits <= cfg_data[5:0];
                REG_CBYTES: cfg_reg.cbytes <= cfg_data[3:0];
                REG_SCOUNT: cfg_reg.scount <= cfg_data[8:0];
                REG_STEP:   cfg_reg.step <= cfg_data;
                default: ;
            endcase
        end
    end

    sacs_ram #(.WIDTH(32), .DEPTH(MAX_SEQUENCES)) u_start (.clk, .we(seq_we),
        .waddr(SEQ_AW'(entry_index)), .wdata(seq_start), .raddr(seq_raddr), .rdata(start_rdata));
    sacs_ram #(.WIDTH(32), .DEPTH(MAX_SEQUENCES)) u_len (.clk, .we(seq_we),
        .waddr(SEQ_AW'(entry_index)), .wdata(seq_length), .raddr(seq_raddr), .rdata(len_rdata));
    sacs_ram #(.WIDTH(8), .DEPTH(MAX_SEQUENCES)) u_order (.clk, .we(seq_we),
        .waddr(SEQ_AW'(entry_index)), .wdata(seq_order), .raddr(seq_raddr), .rdata(order_rdata));
    sacs_ram #(.WIDTH(8), .DEPTH(BUCKET_ENTRIES)) u_bkt (.clk, .we(bkt_we),
        .waddr(BKT_AW'(entry_index)), .wdata(bucket_seq), .raddr(bkt_raddr), .rdata(bkt_rdata));

    sacs_front u_front (.clk, .rst_n, .cfg(cfg_reg), .hold, .push, .full, .command,
        .batch_start, .suffix_pos, .job_valid, .job, .job_ready);

    sacs_back u_back (.clk, .rst_n, .cfg(cfg_reg), .job_valid, .job, .job_ready,
        .bkt_raddr, .bkt_rdata, .seq_raddr, .start_rdata, .len_rdata, .order_rdata,
        .empty, .pop, .code_byte, .last_byte);
endmodule
`default_nettype wire

[hw/rtl/sacs_checker.sv]
`default_nettype none
module sacs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] code_byte,
    input wire logic       last_byte
);
    // a result waiting and not taken holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(code_byte) && $stable(last_byte)))
        else $error("result changed while stalled");
    // no code byte shows in the cycle right after another code's last byte is taken
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_byte) |=> empty)
        else $error("code follows too early");
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_byte) |=> !empty)
        else $error("code broken off");
endmodule
bind suffix_array_checkpoint_sampler_core sacs_checker u_chk (.clk, .rst_n, .empty, .pop,
    .code_byte, .last_byte);
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
    import sacs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  cmd;
        logic [9:0]  idx;
        logic [31:0] sst;
        logic [31:0] slen;
        logic [7:0]  sord;
        logic [7:0]  bseq;
        logic [31:0] bst;
        logic [31:0] pos;
        logic        bend;
    } item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } code_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        push = 0;
    logic        full;
    logic [1:0]  command = '0;
    logic [9:0]  entry_index = '0;
    logic [31:0] seq_start = '0;
    logic [31:0] seq_length = '0;
    logic [7:0]  seq_order = '0;
    logic [7:0]  bucket_seq = '0;
    logic [31:0] batch_start = '0;
    logic [31:0] suffix_pos = '0;
    logic        batch_end = 0;
    logic        empty;
    logic        pop = 0;
    logic [7:0]  code_byte;
    logic        last_byte;

    suffix_array_checkpoint_sampler_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .command(command), .entry_index(entry_index),
        .seq_start(seq_start), .seq_length(seq_length), .seq_order(seq_order),
        .bucket_seq(bucket_seq), .batch_start(batch_start),
        .suffix_pos(suffix_pos), .batch_end(batch_end),
        .empty(empty), .pop(pop), .code_byte(code_byte), .last_byte(last_byte)
    );

    item_t item_q[$];
    code_t code_q[$];
    item_t cur_item;
    logic  took = 0;
    int    send_wait = 0;
    int    pop_wait = 0;
    bit    no_gaps = 0;
    int    errs = 0;

    // shadow of the block state
    logic [31:0] m_start[MAX_SEQUENCES];
    logic [31:0] m_len[MAX_SEQUENCES];
    logic [7:0]  m_order[MAX_SEQUENCES];
    logic [7:0]  m_bucket[BUCKET_ENTRIES];
    logic [32:0] m_rank = '0;
    logic [4:0]  m_ckpt = 5'd5;
    logic [5:0]  m_pbits = 6'd32;
    logic [3:0]  m_cbytes = 4'd5;
    logic [8:0]  m_scount = 9'd1;
    logic [31:0] m_step = 32'd1;

    // sequence layout of the current phase
    logic [31:0] lay_start[MAX_SEQUENCES];
    logic [31:0] lay_len[MAX_SEQUENCES];
    int          lay_n;

    initial begin
        forever #2 clk = ~clk;
    end

    task automatic predict_codes(input item_t it);
        logic [32:0] r;
        logic [32:0] mask;
        logic [31:0] bstep;
        logic [31:0] b;
        logic [63:0] val;
        int          idx;
        int          lastseq;
        int          nb;
        code_t       c;
        case (it.cmd)
            CMD_LOAD_SEQ:
                if (it.idx < MAX_SEQUENCES) begin
                    m_start[it.idx] = it.sst;
                    m_len[it.idx] = it.slen;
                    m_order[it.idx] = it.sord;
                end
            CMD_LOAD_BUCKET:
                m_bucket[it.idx] = it.bseq;
            CMD_BEGIN:
                m_rank = {1'b0, it.bst} + {24'd0, m_scount};
            default:
            begin
                r = m_rank;
                m_rank = m_rank + 33'd1;
                mask = (33'd1 << m_ckpt) - 33'd1;
                if ((r & mask) == 0) begin
                    bstep = (m_step == 0) ? 32'd1 : m_step;
                    b = it.pos / bstep;
                    if (b > BUCKET_ENTRIES - 1)
                        b = BUCKET_ENTRIES - 1;
                    lastseq = (m_scount == 0) ? 0 :
                              (m_scount > MAX_SEQUENCES) ? MAX_SEQUENCES - 1 : m_scount - 1;
                    idx = m_bucket[b];
                    if (idx > lastseq)
                        idx = lastseq;
                    while (idx < lastseq &&
                           {32'd0, it.pos} > {32'd0, m_start[idx]} + {32'd0, m_len[idx]})
                        idx++;
                    val = ({56'd0, m_order[idx]} << m_pbits) +
                          ({32'd0, it.pos} - {32'd0, m_start[idx]});
                    nb = (m_cbytes == 0) ? 1 :
                         (m_cbytes > MAX_CODE_BYTES) ? MAX_CODE_BYTES : m_cbytes;
                    for (int i = 0; i < nb; i++) begin
                        c.data = 8'(val >> (8 * (nb - 1 - i)));
                        c.last = (i == nb - 1);
                        code_q.push_back(c);
                    end
                end
            end
        endcase
    endtask

    // sender: hold the item until it transfers, then idle a drawn number of cycles
    always @(negedge clk) begin
        if (rst_n && (!push || took)) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                push <= 0;
            end else if (item_q.size() != 0) begin
                cur_item = item_q.pop_front();
                command <= cur_item.cmd;
                entry_index <= cur_item.idx;
                seq_start <= cur_item.sst;
                seq_length <= cur_item.slen;
                seq_order <= cur_item.sord;
                bucket_seq <= cur_item.bseq;
                batch_start <= cur_item.bst;
                suffix_pos <= cur_item.pos;
                batch_end <= cur_item.bend;
                push <= 1;
                send_wait <= no_gaps ? 0 : $urandom_range(0, 8);
            end else begin
                push <= 0;
            end
        end
        took <= 0;
    end

    // receiver stall
    always @(negedge clk) begin
        if (rst_n) begin
            if (pop_wait > 0) begin
                pop <= 0;
                pop_wait <= pop_wait - 1;
            end else begin
                pop <= 1;
            end
        end
    end

    always @(posedge clk) begin
        code_t e;
        if (rst_n) begin
            if (push && !full) begin
                predict_codes(cur_item);
                took <= 1;
            end
            if (pop && !empty) begin
                if (code_q.size() == 0) begin
                    $error("unexpected code byte %02h last %0b", code_byte, last_byte);
                    errs++;
                end else begin
                    e = code_q.pop_front();
                    if (code_byte !== e.data) begin
                        $error("code_byte expected %02h actual %02h", e.data, code_byte);
                        errs++;
                    end
                    if (last_byte !== e.last) begin
                        $error("last_byte expected %0b actual %0b", e.last, last_byte);
                        errs++;
                    end
                end
                pop_wait <= no_gaps ? 0 : $urandom_range(0, 8);
            end
        end
    end

    function automatic item_t rand_item(input logic [1:0] cmd);
        item_t it;
        it.cmd = cmd;
        it.idx = 10'($urandom_range(0, 1023));
        it.sst = $urandom;
        it.slen = $urandom;
        it.sord = 8'($urandom);
        it.bseq = 8'($urandom);
        it.bst = $urandom;
        it.pos = $urandom;
        it.bend = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic add_item(input logic [1:0] cmd, input logic [9:0] idx,
                            input logic [31:0] bst, input logic [31:0] pos);
        item_t it;
        it = rand_item(cmd);
        it.idx = idx;
        it.bst = bst;
        it.pos = pos;
        item_q.push_back(it);
    endtask

    task automatic drain;
        while (item_q.size() != 0 || push || code_q.size() != 0)
            @(posedge clk);
        // let an unsampled tail and any walk in flight settle
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_CKPT:   m_ckpt = data[4:0];
            REG_PBITS:  m_pbits = data[5:0];
            REG_CBYTES: m_cbytes = data[3:0];
            REG_SCOUNT: m_scount = data[8:0];
            REG_STEP:   m_step = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // load the layout and the first nbk bucket entries
    task automatic load_tables(input logic [31:0] bstep, input int nbk, input bit noisy);
        item_t       it;
        logic [63:0] p;
        int          j;
        for (int i = 0; i < lay_n; i++) begin
            it = rand_item(CMD_LOAD_SEQ);
            it.idx = 10'(i);
            it.sst = lay_start[i];
            it.slen = lay_len[i];
            item_q.push_back(it);
        end
        for (int b = 0; b < nbk; b++) begin
            p = 64'(b) * 64'(bstep);
            j = 0;
            while (j < lay_n - 1 && p > {32'd0, lay_start[j]} + {32'd0, lay_len[j]})
                j++;
            it = rand_item(CMD_LOAD_BUCKET);
            it.idx = 10'(b);
            if (!noisy || $urandom_range(0, 15) != 0)
                it.bseq = 8'(j);
            item_q.push_back(it);
        end
    endtask

    task automatic run_phase(input int ckpt, input int pbits, input int cbytes,
                             input int scount, input logic [31:0] step_val, input bit auto_step,
                             input logic [31:0] base, input int maxlen, input int count,
                             input logic [31:0] bst);
        logic [31:0] bstep;
        logic [31:0] eff;
        logic [63:0] maxpos;
        logic [63:0] bmax;
        int          nbk;
        int          k;
        int          s;
        item_t       it;
        drain();
        no_gaps = ($urandom_range(0, 3) == 0);
        lay_n = (scount == 0) ? 1 : (scount > MAX_SEQUENCES) ? MAX_SEQUENCES : scount;
        for (int i = 0; i < lay_n; i++) begin
            lay_start[i] = (i == 0) ? base : lay_start[i-1] + lay_len[i-1] + 1;
            lay_len[i] = $urandom_range(0, maxlen);
        end
        // positions stay at or below maxpos, so only the buckets up to it are read
        maxpos = {32'd0, lay_start[lay_n-1]} + {32'd0, lay_len[lay_n-1]} + 64'd8;
        if (maxpos > 64'hFFFF_FFFF)
            maxpos = 64'hFFFF_FFFF;
        bstep = auto_step ? 32'(maxpos / 64'd12) + 32'd1 : step_val;
        eff = (bstep == 0) ? 32'd1 : bstep;
        bmax = maxpos / {32'd0, eff};
        nbk = (bmax >= 64'(BUCKET_ENTRIES)) ? BUCKET_ENTRIES : int'(bmax) + 1;
        write_reg(REG_CKPT, ckpt);
        write_reg(REG_PBITS, pbits);
        write_reg(REG_CBYTES, cbytes);
        write_reg(REG_SCOUNT, scount);
        write_reg(REG_STEP, bstep);
        load_tables(eff, nbk, 1);
        add_item(CMD_BEGIN, 0, bst, 0);
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 15);
            if (k == 0) begin
                item_q.push_back(rand_item(CMD_BEGIN));
            end else if (k == 1) begin
                item_q.push_back(rand_item(2'($urandom_range(0, 1))));
            end else if (k == 2) begin
                it = rand_item(CMD_SUFFIX);
                it.pos = $urandom_range(0, 32'(maxpos));
                item_q.push_back(it);
            end else begin
                it = rand_item(CMD_SUFFIX);
                s = $urandom_range(0, lay_n - 1);
                it.pos = lay_start[s] + $urandom_range(0, lay_len[s]);
                item_q.push_back(it);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // reset settings: one sequence, unit bucket step, sampling every 32nd rank
        lay_n = 1;
        lay_start[0] = 32'h10;
        lay_len[0] = 32'hFFFF_FF00;
        load_tables(1, 1, 0);
        add_item(CMD_LOAD_BUCKET, 10'd16, 0, 0);
        item_q.push_back('{CMD_LOAD_SEQ, 10'd0, 32'h10, 32'hFFFF_FF00, 8'hFF, 8'h00,
                           32'h0, 32'h0, 1'b0});
        item_q.push_back('{CMD_LOAD_SEQ, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        item_q.push_back('{CMD_LOAD_BUCKET, 10'd1023, 32'h0, 32'h0, 8'h0, 8'hFF,
                           32'h0, 32'h0, 1'b0});
        // rank 2^32, position before the sequence start
        add_item(CMD_BEGIN, 0, 32'hFFFF_FFFF, 0);
        add_item(CMD_SUFFIX, 0, 0, 32'h0);
        add_item(CMD_SUFFIX, 0, 0, 32'h1234_5678);
        add_item(CMD_BEGIN, 0, 32'd31, 0);
        add_item(CMD_SUFFIX, 0, 0, 32'hFFFF_FFFF);
        add_item(CMD_BEGIN, 0, 32'hFFFF_FFDF, 0);
        add_item(CMD_SUFFIX, 0, 0, 32'h10);
        add_item(CMD_BEGIN, 0, 32'd0, 0);
        for (int i = 0; i < 31; i++)
            add_item(CMD_SUFFIX, 0, 0, $urandom);
        add_item(CMD_SUFFIX, 0, 0, 32'h8000_0000);

        run_phase(0, 32, 8, 16, 0, 1, 32'h0, 40, 50, $urandom);
        run_phase(2, 1, 1, 17, 0, 1, 32'h7000_0000, 2000, 45, $urandom);
        run_phase(31, 20, 0, 5, 0, 0, 32'h0, 3, 40, 32'h8000_0000 - 5 - 3);
        run_phase(3, 12, 15, 0, 32'hFFFF_FFFF, 0, 32'h1234_0000, 100, 50, $urandom);
        run_phase(1, 24, 4, 20, 0, 1, 32'hF000_0000, 1000000, 50, $urandom);
        run_phase(0, 9, 3, 5, 0, 1, 32'h0, 50, 30, $urandom);

        drain();
        if (errs == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hw/rtl/sacs_pkg.sv
hw/rtl/sacs_ram.sv
hw/rtl/sacs_front.sv
hw/rtl/sacs_back.sv
hw/rtl/suffix_array_checkpoint_sampler_core.sv
hw/rtl/sacs_checker.sv
tb/testbench.sv
